>>> hdl/ffact_pkg.sv
package ffact_pkg;

  localparam int ADDR_W = 32;
  localparam int LIM_W  = 5;
  localparam int OCC_W  = 5;

  // line limit after reset
  localparam logic [LIM_W-1:0] LIMIT_RESET = 5'd16;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic              shift;  // miss accepted: age every line by one place
    logic [ADDR_W-1:0] key;    // address under lookup
  } cell_ctl_t;

endpackage

>>> hdl/ffact_cell.sv
module ffact_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                        clk,
  input  ffact_pkg::cell_ctl_t        ctl,
  input  logic [CW-1:0]               count,
  input  logic [ffact_pkg::ADDR_W-1:0] data_in,
  output logic [ffact_pkg::ADDR_W-1:0] data_out,
  output logic                        match_o,
  output logic [ffact_pkg::ADDR_W-1:0] victim_o
);

  logic [ffact_pkg::ADDR_W-1:0] data_r;
  logic [ffact_pkg::ADDR_W-1:0] data_nxt;
  logic                         held;
  logic                         oldest;

  // this place holds a line only below the occupancy
  assign held   = CW'(IDX) < count;
  assign oldest = count == CW'(IDX + 1);

  assign data_nxt = ctl.shift ? data_in : data_r;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign match_o  = held && (data_r == ctl.key);
  assign victim_o = oldest ? data_r : '0;

endmodule

>>> hdl/fifo_fully_assoc_cache_tags.sv
// channel  | ports                                   | direction
// ---------+-----------------------------------------+-----------
// in       | in_valid/in_ready, in_access_addr       | word in
// out      | out_valid/out_ready, out_hit,           | word out
//          | out_evict_valid, out_evicted_addr,      |
//          | out_occupancy                           |
// cfg      | cfg_we, cfg_wdata (line limit)          | write only
//
// one word per cycle unless the output stalls: lookup, ageing and result all
// happen in the cycle of acceptance, the output register holds the result in
// the next cycle; lookup is each cell's compare plus the or tree over the row
// synchronous active-low reset empties the store (occupancy 0), limit back to 16
// a stalled result holds the output register; a new word is taken in the same
// cycle the held one leaves
module fifo_fully_assoc_cache_tags #(
  parameter int LINES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffact_pkg::ADDR_W-1:0]  in_access_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic                          out_evict_valid,
  output logic [ffact_pkg::ADDR_W-1:0]  out_evicted_addr,
  output logic [ffact_pkg::OCC_W-1:0]   out_occupancy,
  input  logic                          cfg_we,
  input  logic [ffact_pkg::LIM_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(LINES + 1);

  // control state
  logic [ffact_pkg::LIM_W-1:0]  limit_r;
  logic [CW-1:0]                count_r;
  logic [CW-1:0]                count_nxt;
  logic                         out_valid_r;

  // result register, no reset needed
  logic                         hit_r;
  logic                         evict_r;
  logic [ffact_pkg::ADDR_W-1:0] victim_r;
  logic [ffact_pkg::OCC_W-1:0]  occ_r;

  logic                         accept;
  logic                         hit;
  logic                         evict;
  logic [ffact_pkg::ADDR_W-1:0] victim;
  logic [31:0]                  lim_ext;
  logic [31:0]                  eff32;
  logic [CW-1:0]                eff_lim;
  ffact_pkg::cell_ctl_t         ctl;

  logic [ffact_pkg::ADDR_W-1:0] cell_q      [LINES];
  logic [ffact_pkg::ADDR_W-1:0] cell_victim [LINES];
  logic [LINES-1:0]             cell_match;

  // next word may enter as soon as the held result is leaving
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // limit of zero acts as one, above the built capacity acts as the capacity
  assign lim_ext = {{(32 - ffact_pkg::LIM_W){1'b0}}, limit_r};
  assign eff32   = (lim_ext == 32'd0) ? 32'd1 :
                   (lim_ext > 32'(LINES)) ? 32'(LINES) : lim_ext;
  assign eff_lim = eff32[CW-1:0];

  assign ctl.key   = in_access_addr;
  assign ctl.shift = accept && !hit;

  // row of cells, newest line in cell 0, each cell fed by its younger neighbour
  for (genvar i = 0; i < LINES; i++) begin : g_cell
    logic [ffact_pkg::ADDR_W-1:0] d_in;
    if (i == 0) begin : g_head
      assign d_in = in_access_addr;
    end else begin : g_body
      assign d_in = cell_q[i-1];
    end
    ffact_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count_r),
      .data_in  (d_in),
      .data_out (cell_q[i]),
      .match_o  (cell_match[i]),
      .victim_o (cell_victim[i])
    );
  end

  // only the oldest cell drives a non-zero victim
  always_comb begin
    victim = '0;
    for (int i = 0; i < LINES; i++) begin
      victim = victim | cell_victim[i];
    end
  end

  assign hit   = |cell_match;
  // store full against the limit: the oldest line falls off the end of the row
  assign evict = !hit && (count_r >= eff_lim);

  always_comb begin
    count_nxt = count_r;
    if (accept && !hit && !evict) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= ffact_pkg::LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit_r    <= hit;
      evict_r  <= evict;
      victim_r <= evict ? victim : '0;
      occ_r    <= ffact_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_evict_valid  = evict_r;
  assign out_evicted_addr = victim_r;
  assign out_occupancy    = occ_r;

endmodule

>>> hdl/ffact_chk.sv
module ffact_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic                          out_evict_valid,
  input logic [ffact_pkg::ADDR_W-1:0]  out_evicted_addr,
  input logic [ffact_pkg::OCC_W-1:0]   out_occupancy
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_evict_valid) && $stable(out_evicted_addr) && $stable(out_occupancy))
    else $error("result changed while stalled");

  // every accepted word yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // a hit never drops a line
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_evict_valid)
    else $error("eviction on a hit");

  // no eviction means a zero victim address
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evict_valid |-> out_evicted_addr == '0)
    else $error("victim address without eviction");

  // after any access at least one line is held
  a_occ_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy != '0)
    else $error("empty store after an access");

endmodule

bind fifo_fully_assoc_cache_tags ffact_chk u_ffact_chk (.*);

>>> verif/fifo_fully_assoc_cache_tags_tb.sv
`timescale 1ns / 1ps

module fifo_fully_assoc_cache_tags_tb;

  localparam int LINES = 16;
  // cycles with no word moving on any port before the run is given up
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_WORDS = 250;
  localparam int POOL_SIZE = 24;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_PRINTED = 100;

  // one result word as the block reports it
  typedef struct packed {
    logic                         hit;
    logic                         evict_valid;
    logic [ffact_pkg::ADDR_W-1:0] evicted_addr;
    logic [ffact_pkg::OCC_W-1:0]  occupancy;
  } tag_result_t;

  // a word on its way into the block, with an optional hand-typed expectation
  typedef struct packed {
    logic        typed;
    tag_result_t want;
  } offer_t;

  typedef enum logic [1:0] {
    ROW_ACCESS,  // one access word
    ROW_LIMIT,   // drain, then write the line limit
    ROW_SWEEP    // LINES consecutive addresses from the given base
  } row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [ffact_pkg::ADDR_W-1:0] value;
    logic                         typed;
    tag_result_t                  want;
  } dir_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [ffact_pkg::ADDR_W-1:0] in_access_addr;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_hit;
  logic                         out_evict_valid;
  logic [ffact_pkg::ADDR_W-1:0] out_evicted_addr;
  logic [ffact_pkg::OCC_W-1:0]  out_occupancy;
  logic                         cfg_we;
  logic [ffact_pkg::LIM_W-1:0]  cfg_wdata;

  // predictor copy of the tag store, position 0 newest
  logic [ffact_pkg::ADDR_W-1:0] tag_lines [LINES];
  int unsigned                  tag_count;
  logic [ffact_pkg::LIM_W-1:0]  tag_limit;

  tag_result_t                  pending_results[$];
  offer_t                       offers_in_flight[$];
  dir_row_t                     directed_rows[$];
  logic [ffact_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

  int mismatches;
  int quiet_cycles;
  int idle_pct;        // sender gap chance per word, in percent
  int stall_pct;       // receiver stall chance per cycle, in percent
  int hold_requests;   // bumped by the stimulus to ask for a long hold-off

  fifo_fully_assoc_cache_tags #(
    .LINES(LINES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_access_addr  (in_access_addr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_evict_valid (out_evict_valid),
    .out_evicted_addr(out_evicted_addr),
    .out_occupancy   (out_occupancy),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // limit as the store applies it: zero acts as one, above capacity acts as LINES
  function automatic int unsigned lines_in_use(input logic [ffact_pkg::LIM_W-1:0] lim);
    if (lim == 0) return 1;
    if (lim > LINES) return LINES;
    return lim;
  endfunction

  // lookup and fifo replacement on the predictor copy
  task automatic tag_lookup(input logic [ffact_pkg::ADDR_W-1:0] addr,
                            output tag_result_t res);
    int unsigned eff;
    int unsigned n;
    bit          found;
    eff = lines_in_use(tag_limit);
    n = tag_count;
    found = 0;
    res = '0;
    // only held lines take part in the compare
    for (int i = 0; i < n; i++) begin
      if (tag_lines[i] == addr) found = 1;
    end
    if (!found) begin
      if (n >= eff && n > 0) begin
        // store at or over its limit: the oldest line falls off, count unchanged
        res.evict_valid = 1'b1;
        res.evicted_addr = tag_lines[n-1];
        for (int i = n - 1; i > 0; i--) tag_lines[i] = tag_lines[i-1];
      end else begin
        for (int i = n; i > 0; i--) tag_lines[i] = tag_lines[i-1];
        n++;
      end
      tag_lines[0] = addr;
      tag_count = n;
    end
    res.hit = found;
    res.occupancy = tag_count[ffact_pkg::OCC_W-1:0];
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [ffact_pkg::ADDR_W-1:0] got,
                                 input logic [ffact_pkg::ADDR_W-1:0] want);
    // keep the log short when everything goes wrong at once
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // checker and predictor share one block so queue order is fixed per edge:
  // the leaving word is checked before the arriving word is predicted
  always @(posedge clk) begin
    tag_result_t want;
    offer_t      offer;
    bit          moved;
    if (!rst_n) begin
      tag_count = 0;
      tag_limit = ffact_pkg::LIMIT_RESET;
      quiet_cycles = 0;
    end else begin
      moved = cfg_we;
      if (out_valid && out_ready) begin
        moved = 1;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", {31'b0, out_hit}, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_hit !== want.hit)
            report_mismatch("hit", {31'b0, out_hit}, {31'b0, want.hit});
          if (out_evict_valid !== want.evict_valid)
            report_mismatch("evict_valid", {31'b0, out_evict_valid},
                            {31'b0, want.evict_valid});
          if (out_evicted_addr !== want.evicted_addr)
            report_mismatch("evicted_addr", out_evicted_addr, want.evicted_addr);
          if (out_occupancy !== want.occupancy)
            report_mismatch("occupancy", {27'b0, out_occupancy}, {27'b0, want.occupancy});
        end
      end
      if (cfg_we) tag_limit = cfg_wdata;
      if (in_valid && in_ready) begin
        moved = 1;
        offer = offers_in_flight.pop_front();
        tag_lookup(in_access_addr, want);
        // a hand-typed row overrides the prediction, the store copy still advances
        pending_results.push_back(offer.typed ? offer.want : want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("fifo_fully_assoc_cache_tags_tb failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here when asked for
  initial begin
    int hold_left;
    int hold_served;
    out_ready = 1'b0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one word; valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(input logic [ffact_pkg::ADDR_W-1:0] addr, input logic typed,
                           input tag_result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offers_in_flight.push_back({typed, want});
    in_valid <= 1'b1;
    in_access_addr <= addr;
    do @(posedge clk); while (!in_ready);
  endtask

  // sender goes quiet until every result is back, then a little latency margin
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (offers_in_flight.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [ffact_pkg::LIM_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_row(input row_kind_e kind, input logic [ffact_pkg::ADDR_W-1:0] value,
                         input logic typed, input logic hit, input logic evict_valid,
                         input logic [ffact_pkg::ADDR_W-1:0] evicted_addr,
                         input logic [ffact_pkg::OCC_W-1:0] occupancy);
    directed_rows.push_back({kind, value, typed, hit, evict_valid, evicted_addr, occupancy});
  endtask

  // mostly reused addresses so hits and evictions of known lines are common
  function automatic logic [ffact_pkg::ADDR_W-1:0] next_addr(input int pool_used);
    if ($urandom_range(99) < 65) return addr_pool[$urandom_range(pool_used - 1)];
    return $urandom();
  endfunction

  initial begin
    logic [ffact_pkg::LIM_W-1:0] phase_limits [8];
    dir_row_t row;
    int pool_used;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_access_addr = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    mismatches = 0;

    // kind, value, typed, hit, evict_valid, evicted_addr, occupancy
    add_row(ROW_ACCESS, 32'h0000_0000, 1, 0, 0, 32'h0, 5'd1);  // empty store misses
    add_row(ROW_ACCESS, 32'h0000_0000, 1, 1, 0, 32'h0, 5'd1);
    add_row(ROW_ACCESS, 32'hFFFF_FFFF, 1, 0, 0, 32'h0, 5'd2);
    add_row(ROW_ACCESS, 32'hFFFF_FFFF, 1, 1, 0, 32'h0, 5'd2);
    add_row(ROW_ACCESS, 32'h0000_0000, 1, 1, 0, 32'h0, 5'd2);  // older line still hits
    add_row(ROW_LIMIT,  32'd0,         0, 0, 0, 32'h0, 5'd0);  // zero acts as one
    // limit under occupancy: one line dropped per miss, occupancy held
    add_row(ROW_ACCESS, 32'h1234_5678, 1, 0, 1, 32'h0000_0000, 5'd2);
    add_row(ROW_ACCESS, 32'hFFFF_FFFF, 1, 1, 0, 32'h0, 5'd2);
    add_row(ROW_ACCESS, 32'hA5A5_A5A5, 1, 0, 1, 32'hFFFF_FFFF, 5'd2);
    add_row(ROW_LIMIT,  32'd31,        0, 0, 0, 32'h0, 5'd0);  // above capacity
    add_row(ROW_SWEEP,  32'h8000_0000, 0, 0, 0, 32'h0, 5'd0);  // fill to capacity
    add_row(ROW_ACCESS, 32'h8000_000F, 1, 1, 0, 32'h0, 5'd16); // newest line
    add_row(ROW_ACCESS, 32'h8000_0000, 1, 1, 0, 32'h0, 5'd16); // oldest line
    add_row(ROW_LIMIT,  32'd17,        0, 0, 0, 32'h0, 5'd0);
    add_row(ROW_ACCESS, 32'h0000_0000, 1, 0, 1, 32'h8000_0000, 5'd16);
    add_row(ROW_LIMIT,  32'd1,         0, 0, 0, 32'h0, 5'd0);  // lowered far below
    add_row(ROW_ACCESS, 32'h5555_5555, 1, 0, 1, 32'h8000_0001, 5'd16);
    add_row(ROW_ACCESS, 32'h5555_5555, 1, 1, 0, 32'h0, 5'd16);
    add_row(ROW_LIMIT,  32'd16,        0, 0, 0, 32'h0, 5'd0);
    add_row(ROW_ACCESS, 32'hAAAA_AAAA, 0, 0, 0, 32'h0, 5'd0);

    phase_limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd3, 5'd17, 5'd2};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed walk, no idling
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      case (row.kind)
        ROW_LIMIT: begin
          wait_drained();
          write_limit(row.value[ffact_pkg::LIM_W-1:0]);
        end
        ROW_SWEEP: begin
          for (int i = 0; i < LINES; i++) send_word(row.value + i, 1'b0, '0);
        end
        default: begin
          send_word(row.value, row.typed, row.want);
        end
      endcase
    end

    // random phases: new limit each phase, idling pattern cycles through
    // none, sender gaps, receiver stalls and both together
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      write_limit(phase_limits[p]);
      pool_used = lines_in_use(phase_limits[p]) + 3;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 60; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 60; end
        default: begin idle_pct = 20; stall_pct <= 20; end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // long receiver hold-off while words keep coming: input must stall
        if (p == 0 && k == PHASE_WORDS / 2) hold_requests <= hold_requests + 1;
        // sender pause until the block has handed back everything
        if (p == 1 && k == PHASE_WORDS / 2) wait_drained();
        send_word(next_addr(pool_used), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("fifo_fully_assoc_cache_tags_tb passed");
    end else begin
      $display("fifo_fully_assoc_cache_tags_tb failed");
    end
    $finish;
  end

endmodule
